// File: rtl/lpg_pkg.sv
// Shared widths, register indexes and controller states of the line pixel generator.
`timescale 1ns / 1ps

package lpg_pkg;

    // Field widths of coordinates and colour.
    localparam int X_W = 10;
    localparam int Y_W = 9;
    localparam int C_W = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = C_W;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_COLOR = 3'd4;

    // Stream payloads, padded to whole bytes.
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_FIELDS_W  = X_W + Y_W + C_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Serial arithmetic: product of |dy| and |x offset|, divided by |dx|.
    localparam int PROD_W    = X_W + Y_W;
    localparam int MUL_CNT_W = $clog2(Y_W + 1);
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// File: rtl/lpg_serial_mul.sv
// Shift-and-add multiplier that takes one multiplier bit per cycle.
`timescale 1ns / 1ps

module lpg_serial_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lpg_pkg::X_W-1:0]    i_mcand,
    input  logic [lpg_pkg::Y_W-1:0]    i_mplier,
    output logic                       o_done,
    output logic [lpg_pkg::PROD_W-1:0] o_product
);
    import lpg_pkg::*;

    logic [PROD_W-1:0]    r_acc;
    logic [PROD_W-1:0]    r_mcand;
    logic [Y_W-1:0]       r_mplier;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // Sequencing: counts down the multiplier bits, done pulses once at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(Y_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand whenever the low multiplier bit is set.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= {{(PROD_W-X_W){1'b0}}, i_mcand};
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[Y_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// File: rtl/lpg_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module lpg_serial_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lpg_pkg::PROD_W-1:0] i_dividend,
    input  logic [lpg_pkg::X_W-1:0]    i_divisor,
    output logic                       o_done,
    output logic [lpg_pkg::PROD_W-1:0] o_quotient
);
    import lpg_pkg::*;

    logic [X_W-1:0]       r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [X_W-1:0]       r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [X_W:0] trial;
    logic [X_W:0] diff;
    logic         fits;

    // Bring down the next dividend bit and try the subtraction.
    always_comb begin
        trial = {r_rem, r_quo[PROD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = trial >= {1'b0, r_dvs};
    end

    // Sequencing: counts down the quotient bits, done pulses once at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out of r_quo as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[X_W-1:0] : trial[X_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/line_pixel_generator.sv
// Top level of the line pixel generator: controller, cursor, registers and output stage.
`timescale 1ns / 1ps

// Generates the pixels of a straight line between the configured endpoints, one pixel
// for each accepted input transfer. A transfer with restart set begins the line at its
// first pixel; a transfer with restart clear advances, and gives no pixel when no line
// is active. Lines whose x coordinates differ step x upward over the whole span with
// y = start_y + dy*(x - start_x)/dx, truncated toward zero; vertical lines step y
// upward; tlast marks the final pixel. A pixel on a line with differing x coordinates
// passes in order through the bit-serial multiplier, which works through the bits of
// |dy|, the hand-over of the product, the restoring divider, which forms the quotient
// bits, the fold of the quotient into y and the load of the output register. A
// vertical-line pixel goes from the idle state straight to the output state and from
// there into the output register; an advance with no active line leaves the block
// idle. One item is in work at a time; the next input transfer is taken as soon as the
// pixel sits in the output register, even while that register still waits to be
// taken, and a pixel that cannot enter the output register holds the input off for as
// long as the output stalls. Registers may be written only while the block is idle;
// writes to indexes beyond the pen colour are ignored.
module line_pixel_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream: bit 0 restart, bits 7:1 zero.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lpg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Output stream: pixel_x [9:0], pixel_y [18:10], pixel_color [42:19], zeros above.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lpg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lpg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lpg_pkg::*;

    // Configuration registers.
    logic [X_W-1:0] r_start_x;
    logic [Y_W-1:0] r_start_y;
    logic [X_W-1:0] r_end_x;
    logic [Y_W-1:0] r_end_y;
    logic [C_W-1:0] r_pen;

    // Line state and controller.
    t_state         r_state, n_state;
    logic [X_W-1:0] r_cursor;
    logic           r_running;

    // Per-pixel working registers.
    logic [X_W-1:0] r_px;
    logic [Y_W-1:0] r_py;
    logic [Y_W-1:0] r_sy;
    logic [C_W-1:0] r_color;
    logic           r_fin;
    logic           r_neg;
    logic [X_W-1:0] r_dx_mag;

    // Output register.
    logic           r_m_valid;
    logic [X_W-1:0] r_m_x;
    logic [Y_W-1:0] r_m_y;
    logic [C_W-1:0] r_m_color;
    logic           r_m_last;

    // Decode of the accepted item.
    logic           in_xfer;
    logic           restart;
    logic           emits;
    logic           horiz;
    logic [X_W-1:0] ax, bx, lo, hi;
    logic [X_W-1:0] cur_eff;
    logic           fin;
    logic [X_W:0]   off_s, off_n, dx_s, dx_n;
    logic [Y_W:0]   dy_s, dy_n;
    logic [X_W-1:0] off_mag, dx_mag;
    logic [Y_W-1:0] dy_mag;

    // Controller outputs and arithmetic unit handshakes.
    logic              mul_start, mul_done;
    logic              div_start, div_done;
    logic              out_load;
    logic [PROD_W-1:0] product, quotient;
    logic [Y_W-1:0]    q_low, q_term;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    // Stepping axis bounds, cursor for this pixel and the signed operands.
    always_comb begin
        restart = s_axis_tdata[0];
        horiz   = (r_start_x != r_end_x);
        ax      = horiz ? r_start_x : {{(X_W-Y_W){1'b0}}, r_start_y};
        bx      = horiz ? r_end_x   : {{(X_W-Y_W){1'b0}}, r_end_y};
        lo      = (ax < bx) ? ax : bx;
        hi      = (ax < bx) ? bx : ax;
        cur_eff = restart ? lo : r_cursor;
        fin     = (cur_eff >= hi);
        emits   = restart || r_running;

        off_s   = {1'b0, cur_eff} - {1'b0, r_start_x};
        off_n   = ~off_s + 1'b1;
        off_mag = off_s[X_W] ? off_n[X_W-1:0] : off_s[X_W-1:0];
        dx_s    = {1'b0, r_end_x} - {1'b0, r_start_x};
        dx_n    = ~dx_s + 1'b1;
        dx_mag  = dx_s[X_W] ? dx_n[X_W-1:0] : dx_s[X_W-1:0];
        dy_s    = {1'b0, r_end_y} - {1'b0, r_start_y};
        dy_n    = ~dy_s + 1'b1;
        dy_mag  = dy_s[Y_W] ? dy_n[Y_W-1:0] : dy_s[Y_W-1:0];
    end

    // Signed quotient folded back into y, modulo the field width.
    always_comb begin
        q_low  = quotient[Y_W-1:0];
        q_term = r_neg ? (~q_low + Y_W'(1)) : q_low;
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_pen     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_X:   r_start_x <= i_cfg_data[X_W-1:0];
                CFG_START_Y:   r_start_y <= i_cfg_data[Y_W-1:0];
                CFG_END_X:     r_end_x   <= i_cfg_data[X_W-1:0];
                CFG_END_Y:     r_end_y   <= i_cfg_data[Y_W-1:0];
                CFG_PEN_COLOR: r_pen     <= i_cfg_data[C_W-1:0];
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit start pulses.
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && emits) begin
                    mul_start = horiz;
                    n_state   = horiz ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Cursor and line activity advance on each transfer that yields a pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_running <= 1'b0;
        end else if (in_xfer && emits) begin
            r_cursor  <= fin ? cur_eff : cur_eff + 1'b1;
            r_running <= !fin;
        end
    end

    // Capture of the pixel's operands, and of y once the division finishes.
    always_ff @(posedge i_clk) begin
        if (in_xfer && emits) begin
            r_px     <= horiz ? cur_eff : r_start_x;
            r_py     <= cur_eff[Y_W-1:0];
            r_sy     <= r_start_y;
            r_color  <= r_pen;
            r_fin    <= fin;
            r_neg    <= off_s[X_W] ^ dx_s[X_W] ^ dy_s[Y_W];
            r_dx_mag <= dx_mag;
        end else if (div_done) begin
            r_py <= r_sy + q_term;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_x     <= r_px;
            r_m_y     <= r_py;
            r_m_color <= r_color;
            r_m_last  <= r_fin;
        end
    end

    lpg_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (off_mag),
        .i_mplier  (dy_mag),
        .o_done    (mul_done),
        .o_product (product)
    );

    lpg_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_dx_mag),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, r_m_color, r_m_y, r_m_x};

endmodule

// File: rtl/lpg_checker.sv
// Port-level checks of the line pixel generator, bound to its top level.
`timescale 1ns / 1ps

module lpg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [lpg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);
    import lpg_pkg::*;

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // A stalled pixel holds its value and its end-of-line mark.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("pixel changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("pixel shown after reset");

    // A restart always yields a pixel, so the block is busy right after it.
    a_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && s_axis_tdata[0] |=> !s_axis_tready)
        else $error("input still ready after a restart transfer");

    // No pixel can reach the output in the cycle right after a transfer.
    a_no_instant_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !$rose(m_axis_tvalid))
        else $error("pixel appeared one cycle after its transfer");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
